FILE: design/hit_time_gap_clusterer_top_macros.svh
// ----------------------------------------------------------------------------
// hit_time_gap_clusterer_top_macros
// Assertion macros shared by the clusterer RTL. Expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HIT_TIME_GAP_CLUSTERER_TOP_MACROS_SVH
`define HIT_TIME_GAP_CLUSTERER_TOP_MACROS_SVH

// same-cycle implication
`define HTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/htg_pkg.sv
// ----------------------------------------------------------------------------
// htg_pkg
// Shared constants and control types of the hit time gap clusterer.
// ----------------------------------------------------------------------------
package htg_pkg;

  localparam int HIT_TIME_W    = 24;
  localparam int GAP_W         = 24;
  localparam int IDX_OUT_W     = 6;
  localparam int CNT_OUT_W     = 7;
  localparam int MAX_HITS_DEF  = 64;
  localparam int TIME_BITS_DEF = 24;

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(300);

  typedef struct packed {
    logic drain;
    logic drain_first;
    logic emit;
  } lbl_ctrl_t;

  typedef struct packed {
    logic emit_done;
  } lbl_stat_t;

endpackage

FILE: design/htg_in_if.sv
// ----------------------------------------------------------------------------
// htg_in_if
// Input channel: one hit word per handshake.
// ----------------------------------------------------------------------------
interface htg_in_if;
  logic                           valid;
  logic                           ready;
  logic                           hit_present;
  logic [htg_pkg::HIT_TIME_W-1:0] hit_time;
  logic                           end_of_event;

  modport source (output valid, hit_present, hit_time, end_of_event, input ready);
  modport sink   (input valid, hit_present, hit_time, end_of_event, output ready);
endinterface

FILE: design/htg_out_if.sv
// ----------------------------------------------------------------------------
// htg_out_if
// Result channel: one result word per hit, or one for an empty event.
// ----------------------------------------------------------------------------
interface htg_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit_valid;
  logic [htg_pkg::IDX_OUT_W-1:0] hit_index;
  logic [htg_pkg::IDX_OUT_W-1:0] subevent_number;
  logic [htg_pkg::CNT_OUT_W-1:0] subevent_count;
  logic                          overflow;
  logic                          last_result;

  modport source (output valid, hit_valid, hit_index, subevent_number, subevent_count,
                  overflow, last_result, input ready);
  modport sink   (input valid, hit_valid, hit_index, subevent_number, subevent_count,
                  overflow, last_result, output ready);
endinterface

FILE: design/hit_time_gap_clusterer_top.sv
// ----------------------------------------------------------------------------
// hit_time_gap_clusterer_top
// Sorts the hit times of one event and groups them into subevents by gap.
// ----------------------------------------------------------------------------
// in_ch takes one word per hit; end_of_event closes the event, and a word with
// no hit and the end mark closes an empty event. Up to MAX_HITS hits are kept,
// later ones are dropped and flagged in overflow. cfg_we/cfg_wdata set max_gap.
// Each accepted hit is inserted into a chain of MAX_HITS sorting cells. After
// the end mark the chain drains one cell per cycle into the labeler, which
// numbers subevents and stores them by load index. Results then leave out_ch
// in load order, one per cycle while out_ch is ready, through a registered
// memory read and an output register. in_ch is not ready from the end mark
// until the last result of the event has entered the output register. A
// stalled out_ch holds the output register and pauses emission; nothing is
// lost. Reset empties the chain, clears the hit count and overflow flag, and
// sets max_gap to 300.
// ----------------------------------------------------------------------------
`include "hit_time_gap_clusterer_top_macros.svh"

module hit_time_gap_clusterer_top #(
  parameter int MAX_HITS  = htg_pkg::MAX_HITS_DEF,
  parameter int TIME_BITS = htg_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  htg_in_if.sink                    in_ch,
  htg_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [htg_pkg::GAP_W-1:0] cfg_wdata
);
  import htg_pkg::*;

  localparam int IW = $clog2(MAX_HITS);
  localparam int CW = $clog2(MAX_HITS + 1);
  localparam int KW = (TIME_BITS < HIT_TIME_W) ? TIME_BITS : HIT_TIME_W;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  hit_total_r, hit_total_nxt;
  logic [CW-1:0]  drain_cnt_r, drain_cnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic [GAP_W-1:0] max_gap_r;

  logic           in_acc;
  logic           insert;
  logic [TIME_BITS-1:0] new_tstamp;

  lbl_ctrl_t      lbl_ctrl;
  lbl_stat_t      lbl_stat;

  logic [MAX_HITS-1:0]  c_valid;
  logic [MAX_HITS-1:0]  c_gt;
  logic [TIME_BITS-1:0] c_tstamp [MAX_HITS];
  logic [IW-1:0]        c_idx    [MAX_HITS];

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign new_tstamp  = TIME_BITS'(in_ch.hit_time[KW-1:0]);

  always_comb begin
    state_nxt     = state_r;
    hit_total_nxt = hit_total_r;
    drain_cnt_nxt = drain_cnt_r;
    ovf_nxt       = ovf_r;
    insert        = 1'b0;
    lbl_ctrl      = '0;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (in_ch.hit_present) begin
            if (hit_total_r < CW'(MAX_HITS)) begin
              insert        = 1'b1;
              hit_total_nxt = hit_total_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_ch.end_of_event) begin
            state_nxt     = ST_DRAIN;
            drain_cnt_nxt = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (drain_cnt_r == hit_total_r) begin
          state_nxt = ST_EMIT;
        end else begin
          lbl_ctrl.drain       = 1'b1;
          lbl_ctrl.drain_first = (drain_cnt_r == '0);
          drain_cnt_nxt        = drain_cnt_r + CW'(1);
        end
      end
      ST_EMIT: begin
        lbl_ctrl.emit = 1'b1;
        if (lbl_stat.emit_done) begin
          state_nxt     = ST_LOAD;
          hit_total_nxt = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      hit_total_r <= '0;
      drain_cnt_r <= '0;
      ovf_r       <= 1'b0;
      max_gap_r   <= GAP_RESET;
    end else begin
      state_r     <= state_nxt;
      hit_total_r <= hit_total_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      ovf_r       <= ovf_nxt;
      if (cfg_we) begin
        max_gap_r <= cfg_wdata;
      end
    end
  end

  // sorting chain, slot 0 holds the earliest time
  for (genvar i = 0; i < MAX_HITS; i++) begin : g_cell
    logic                 lft_gt, lft_valid, rgt_valid;
    logic [TIME_BITS-1:0] lft_tstamp, rgt_tstamp;
    logic [IW-1:0]        lft_idx, rgt_idx;

    if (i == 0) begin : g_first
      assign lft_gt     = 1'b0;
      assign lft_valid  = 1'b0;
      assign lft_tstamp = '0;
      assign lft_idx    = '0;
    end else begin : g_mid
      assign lft_gt     = c_gt[i-1];
      assign lft_valid  = c_valid[i-1];
      assign lft_tstamp = c_tstamp[i-1];
      assign lft_idx    = c_idx[i-1];
    end

    if (i == MAX_HITS - 1) begin : g_last
      assign rgt_valid  = 1'b0;
      assign rgt_tstamp = '0;
      assign rgt_idx    = '0;
    end else begin : g_inner
      assign rgt_valid  = c_valid[i+1];
      assign rgt_tstamp = c_tstamp[i+1];
      assign rgt_idx    = c_idx[i+1];
    end

    htg_cell #(
      .TW (TIME_BITS),
      .IW (IW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .insert      (insert),
      .shift_dn    (lbl_ctrl.drain),
      .new_tstamp  (new_tstamp),
      .new_idx     (hit_total_r[IW-1:0]),
      .lft_gt      (lft_gt),
      .lft_valid   (lft_valid),
      .lft_tstamp  (lft_tstamp),
      .lft_idx     (lft_idx),
      .rgt_valid   (rgt_valid),
      .rgt_tstamp  (rgt_tstamp),
      .rgt_idx     (rgt_idx),
      .cell_valid  (c_valid[i]),
      .cell_tstamp (c_tstamp[i]),
      .cell_idx    (c_idx[i]),
      .cell_gt     (c_gt[i])
    );
  end

  htg_labeler #(
    .MAX_HITS  (MAX_HITS),
    .TIME_BITS (TIME_BITS)
  ) u_labeler (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (lbl_ctrl),
    .stat        (lbl_stat),
    .max_gap     (max_gap_r),
    .head_tstamp (c_tstamp[0]),
    .head_idx    (c_idx[0]),
    .hit_total   (hit_total_r),
    .ovf         (ovf_r),
    .out_ch      (out_ch)
  );

  `HTG_ASSERT_IMP(a_total_cap, 1'b1, hit_total_r <= CW'(MAX_HITS), "hit total past capacity")
  `HTG_ASSERT_IMP(a_drain_head, (state_r == ST_DRAIN) && (drain_cnt_r != hit_total_r),
    c_valid[0], "drain from empty chain head")
  `HTG_ASSERT_IMP(a_chain_empty, (state_r == ST_LOAD) && (hit_total_r == '0),
    !c_valid[0], "chain not empty at event start")
  `HTG_ASSERT_NXT(a_done_clear, lbl_stat.emit_done,
    (state_r == ST_LOAD) && (hit_total_r == '0) && !ovf_r, "event state not cleared")

endmodule

FILE: design/htg_cell.sv
// ----------------------------------------------------------------------------
// htg_cell
// One slot of the sorting chain. Inserts shift larger times up by one slot,
// drains shift the whole chain down toward slot zero.
// ----------------------------------------------------------------------------
module htg_cell #(
  parameter int TW = 24,
  parameter int IW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          insert,
  input  logic          shift_dn,
  input  logic [TW-1:0] new_tstamp,
  input  logic [IW-1:0] new_idx,
  input  logic          lft_gt,
  input  logic          lft_valid,
  input  logic [TW-1:0] lft_tstamp,
  input  logic [IW-1:0] lft_idx,
  input  logic          rgt_valid,
  input  logic [TW-1:0] rgt_tstamp,
  input  logic [IW-1:0] rgt_idx,
  output logic          cell_valid,
  output logic [TW-1:0] cell_tstamp,
  output logic [IW-1:0] cell_idx,
  output logic          cell_gt
);

  logic          valid_r, valid_nxt;
  logic [TW-1:0] tstamp_r, tstamp_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  // empty slot counts as larger than any time
  assign cell_gt = !valid_r || (tstamp_r > new_tstamp);

  always_comb begin
    valid_nxt  = valid_r;
    tstamp_nxt = tstamp_r;
    idx_nxt    = idx_r;
    if (insert && cell_gt) begin
      if (lft_gt) begin
        valid_nxt  = lft_valid;
        tstamp_nxt = lft_tstamp;
        idx_nxt    = lft_idx;
      end else begin
        valid_nxt  = 1'b1;
        tstamp_nxt = new_tstamp;
        idx_nxt    = new_idx;
      end
    end else if (shift_dn) begin
      valid_nxt  = rgt_valid;
      tstamp_nxt = rgt_tstamp;
      idx_nxt    = rgt_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tstamp_r <= tstamp_nxt;
    idx_r    <= idx_nxt;
  end

  assign cell_valid  = valid_r;
  assign cell_tstamp = tstamp_r;
  assign cell_idx    = idx_r;

endmodule

FILE: design/htg_labeler.sv
// ----------------------------------------------------------------------------
// htg_labeler
// Labels the drained sorted times with subevent numbers, stores them by load
// index and streams the results out in load order.
// ----------------------------------------------------------------------------
`include "hit_time_gap_clusterer_top_macros.svh"

module htg_labeler #(
  parameter int MAX_HITS  = 64,
  parameter int TIME_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  htg_pkg::lbl_ctrl_t                      ctrl,
  output htg_pkg::lbl_stat_t                      stat,
  input  logic [htg_pkg::GAP_W-1:0]               max_gap,
  input  logic [TIME_BITS-1:0]                    head_tstamp,
  input  logic [$clog2(MAX_HITS)-1:0]             head_idx,
  input  logic [$clog2(MAX_HITS+1)-1:0]           hit_total,
  input  logic                                    ovf,
  htg_out_if.source                               out_ch
);
  import htg_pkg::*;

  localparam int IW = $clog2(MAX_HITS);
  localparam int CW = $clog2(MAX_HITS + 1);
  localparam int DW = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;

  logic [IW-1:0]        sub_mem [MAX_HITS];
  logic [IW-1:0]        sub_r, sub_nxt;
  logic [TIME_BITS-1:0] prev_r;
  logic [TIME_BITS-1:0] diff;
  logic                 gap_open;

  logic [CW-1:0] issue_cnt_r;
  logic [CW-1:0] ridx_r;
  logic [IW-1:0] rdata_r;
  logic          rv_r, rv_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_hv_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [IDX_OUT_W-1:0] out_sub_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic          out_ovf_r;
  logic          out_last_r;

  logic out_free, n_zero, move, issue, empty_go, last_move;

  // drain side
  assign diff     = head_tstamp - prev_r;
  assign gap_open = !ctrl.drain_first && (DW'(diff) > DW'(max_gap));
  assign sub_nxt  = ctrl.drain_first ? '0 : sub_r + IW'(gap_open);

  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      sub_r  <= sub_nxt;
      prev_r <= head_tstamp;
      sub_mem[head_idx] <= sub_nxt;
    end
    if (issue) begin
      rdata_r <= sub_mem[issue_cnt_r[IW-1:0]];
      ridx_r  <= issue_cnt_r;
    end
  end

  // emit side
  assign out_free  = !out_valid_r || out_ch.ready;
  assign n_zero    = (hit_total == '0);
  assign move      = ctrl.emit && !n_zero && rv_r && out_free;
  assign issue     = ctrl.emit && !n_zero && (issue_cnt_r < hit_total) && (!rv_r || move);
  assign empty_go  = ctrl.emit && n_zero && out_free;
  assign last_move = move && ((ridx_r + CW'(1)) == hit_total);

  assign stat.emit_done = last_move || empty_go;

  always_comb begin
    rv_nxt = rv_r;
    if (issue) begin
      rv_nxt = 1'b1;
    end else if (move) begin
      rv_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (move || empty_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      issue_cnt_r <= '0;
    end else begin
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctrl.drain_first) begin
        issue_cnt_r <= '0;
      end else if (issue) begin
        issue_cnt_r <= issue_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_hv_r   <= 1'b1;
      out_idx_r  <= IDX_OUT_W'(ridx_r);
      out_sub_r  <= IDX_OUT_W'(rdata_r);
      out_cnt_r  <= CNT_OUT_W'(sub_r) + CNT_OUT_W'(1);
      out_ovf_r  <= ovf;
      out_last_r <= (ridx_r + CW'(1)) == hit_total;
    end else if (empty_go) begin
      out_hv_r   <= 1'b0;
      out_idx_r  <= '0;
      out_sub_r  <= '0;
      out_cnt_r  <= '0;
      out_ovf_r  <= ovf;
      out_last_r <= 1'b1;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit_valid       = out_hv_r;
  assign out_ch.hit_index       = out_idx_r;
  assign out_ch.subevent_number = out_sub_r;
  assign out_ch.subevent_count  = out_cnt_r;
  assign out_ch.overflow        = out_ovf_r;
  assign out_ch.last_result     = out_last_r;

  `HTG_ASSERT_IMP(a_lbl_ridx, rv_r, ridx_r < hit_total, "read index past hit total")
  `HTG_ASSERT_IMP(a_lbl_issue, ctrl.emit && !n_zero, issue_cnt_r <= hit_total, "issue count past total")
  `HTG_ASSERT_NXT(a_lbl_move, move, out_valid_r, "moved word not in output register")

endmodule

FILE: tb/hit_time_gap_clusterer_checker.sv
// ----------------------------------------------------------------------------
// hit_time_gap_clusterer_checker
// Watches the hit and result channels of the clusterer. Keeps its own copy
// of the event store and max_gap. When an event closes, it sorts the times,
// splits them into subevents by gap and queues the result words. Each result
// word taken from the block is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module hit_time_gap_clusterer_checker
  import htg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  htg_in_if                in_mon,
  htg_out_if               out_mon,
  input  logic             cfg_we,
  input  logic [GAP_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending,
  output int               results_checked,
  output int               events_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 hit_valid;
    logic [IDX_OUT_W-1:0] hit_index;
    logic [IDX_OUT_W-1:0] subevent_number;
    logic [CNT_OUT_W-1:0] subevent_count;
    logic                 overflow;
    logic                 last_result;
  } cluster_word_t;

  logic [HIT_TIME_W-1:0] ev_times [MAX_HITS_DEF];
  int unsigned           ev_hits;
  logic                  ev_dropped;
  logic [GAP_W-1:0]      gap_limit;
  cluster_word_t         cluster_q[$];

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("word %0d %s got %0d want %0d", results_checked, name, got, want));
  endtask

  // sort the stored times, split by gap, queue one word per hit in load order (one word for an empty event)
  function automatic void close_event();
    logic [HIT_TIME_W-1:0] order [MAX_HITS_DEF];
    logic                  splits [MAX_HITS_DEF];
    logic [HIT_TIME_W-1:0] v;
    int                    j;
    int                    clusters;
    int                    sub;
    cluster_word_t         w;
    w = '0;
    if (ev_hits == 0) begin
      w.overflow    = ev_dropped;
      w.last_result = 1'b1;
      cluster_q.insert(cluster_q.size(), w);
    end else begin
      for (int i = 0; i < ev_hits; i++) order[i] = ev_times[i];
      for (int i = 1; i < ev_hits; i++) begin
        v = order[i];
        j = i;
        while (j > 0 && order[j-1] > v) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
      clusters = 1;
      for (int i = 0; i + 1 < ev_hits; i++) begin
        splits[i] = (order[i+1] - order[i]) > gap_limit;
        if (splits[i]) clusters++;
      end
      for (int k = 0; k < ev_hits; k++) begin
        sub = 0;
        for (int i = 0; i + 1 < ev_hits; i++)
          if (splits[i] && order[i+1] <= ev_times[k]) sub++;
        w.hit_valid       = 1'b1;
        w.hit_index       = IDX_OUT_W'(k);
        w.subevent_number = IDX_OUT_W'(sub);
        w.subevent_count  = CNT_OUT_W'(clusters);
        w.overflow        = ev_dropped;
        w.last_result     = (k + 1 == ev_hits);
        cluster_q.insert(cluster_q.size(), w);
      end
    end
    ev_hits    = 0;
    ev_dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    cluster_word_t got;
    cluster_word_t want;
    if (!rst_n) begin
      ev_hits         = 0;
      ev_dropped      = 1'b0;
      gap_limit       = GAP_RESET;
      cluster_q.delete();
      fail_count      = 0;
      results_checked = 0;
      events_closed   = 0;
    end else begin
      if (cfg_we === 1'b1) gap_limit = cfg_wdata;
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got = '{out_mon.hit_valid, out_mon.hit_index, out_mon.subevent_number,
                out_mon.subevent_count, out_mon.overflow, out_mon.last_result};
        if (cluster_q.size() == 0) begin
          report($sformatf("result word with nothing pending, index %0d", got.hit_index));
        end else begin
          want = cluster_q.pop_front();
          check_field("hit_valid", 8'(got.hit_valid), 8'(want.hit_valid));
          check_field("hit_index", 8'(got.hit_index), 8'(want.hit_index));
          check_field("subevent_number", 8'(got.subevent_number),
                      8'(want.subevent_number));
          check_field("subevent_count", 8'(got.subevent_count), 8'(want.subevent_count));
          check_field("overflow", 8'(got.overflow), 8'(want.overflow));
          check_field("last_result", 8'(got.last_result), 8'(want.last_result));
        end
        results_checked++;
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        if (in_mon.hit_present) begin
          if (ev_hits < MAX_HITS_DEF) begin
            ev_times[ev_hits] = in_mon.hit_time;
            ev_hits++;
          end else begin
            ev_dropped = 1'b1;
          end
        end
        if (in_mon.end_of_event) begin
          close_event();
          events_closed++;
        end
      end
    end
    pending = cluster_q.size();
  end

endmodule

FILE: tb/hit_time_gap_clusterer_top_tb.sv
// ----------------------------------------------------------------------------
// hit_time_gap_clusterer_top_tb
// Drives hit words and max_gap settings into the clusterer and gives the
// verdict. Directed events cover empty events, hitless closing words, time
// extremes, equal times, steps at the gap boundary and a full event with
// dropped hits. Random events then mix clustered times, noise words and
// random stalls on both channels under several gap settings.
// ----------------------------------------------------------------------------
module hit_time_gap_clusterer_top_tb;
  import htg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 32;
  localparam int CYCLE_LIMIT  = 400000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [GAP_W-1:0] cfg_wdata;

  htg_in_if  in_ch();
  htg_out_if out_ch();

  int               fail_count;
  int               pending;
  int               results_checked;
  int               events_closed;
  int               items_sent;
  int               gap_writes;
  int               cycles;
  int               rdy_hold;
  bit               steady;
  logic [GAP_W-1:0] gap_now;

  hit_time_gap_clusterer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hit_time_gap_clusterer_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .events_closed   (events_closed)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rdy_hold <= 0;
    end else if (steady) begin
      out_ch.ready <= 1'b1;
    end else if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      out_ch.ready <= ~out_ch.ready;
      rdy_hold     <= pick_gap();
    end
  end

  // valid stays high after acceptance; lowered only for a gap or when settling
  task automatic send_word(bit present, logic [HIT_TIME_W-1:0] t, bit eoe);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.hit_present  <= present;
    in_ch.hit_time     <= t;
    in_ch.end_of_event <= eoe;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (present || eoe) items_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_gap(logic [GAP_W-1:0] g);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gap_now = g;
    gap_writes++;
  endtask

  task automatic send_event(int n_hits);
    logic [HIT_TIME_W-1:0] t;
    logic [HIT_TIME_W-1:0] step;
    bit                    sep_close;
    int                    r;
    sep_close = (n_hits == 0) || ($urandom_range(0, 3) == 0);
    t    = HIT_TIME_W'($urandom());
    step = '0;
    for (int h = 0; h < n_hits; h++) begin
      if ($urandom_range(0, 9) == 0) send_word(1'b0, HIT_TIME_W'($urandom()), 1'b0);
      r = $urandom_range(0, 9);
      case (r)
        0:       t = HIT_TIME_W'($urandom());
        1:       step = gap_now;
        2:       step = HIT_TIME_W'(gap_now + 1);
        3, 4:    step = HIT_TIME_W'(gap_now + 1 + $urandom_range(0, 255));
        default: step = HIT_TIME_W'($urandom_range(0, gap_now));
      endcase
      if (r != 0) t = $urandom_range(0, 1) ? t + step : t - step;
      send_word(1'b1, t, !sep_close && (h == n_hits - 1));
    end
    if (sep_close) send_word(1'b0, HIT_TIME_W'($urandom()), 1'b1);
  endtask

  initial begin
    logic [HIT_TIME_W-1:0] base;
    logic [GAP_W-1:0]      g;
    int                    random_start;
    int                    n;
    int                    r;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.hit_present  = 1'b0;
    in_ch.hit_time     = '0;
    in_ch.end_of_event = 1'b0;
    out_ch.ready       = 1'b0;
    steady             = 1'b0;
    gap_now            = GAP_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gap of 300
    send_word(1'b0, 24'h123456, 1'b1);
    send_word(1'b0, 24'hABCDEF, 1'b0);
    send_word(1'b1, 24'h000000, 1'b1);
    send_word(1'b1, 24'hFFFFFF, 1'b0);
    send_word(1'b1, 24'h000000, 1'b0);
    send_word(1'b1, 24'hFFFFFF, 1'b1);
    send_word(1'b1, 24'd500, 1'b0);
    send_word(1'b1, 24'd500, 1'b0);
    send_word(1'b1, 24'd500, 1'b1);
    send_word(1'b1, 24'd1300, 1'b0);
    send_word(1'b1, 24'd1601, 1'b0);
    send_word(1'b1, 24'd1000, 1'b0);
    send_word(1'b1, 24'd1000, 1'b1);
    send_word(1'b1, 24'd7, 1'b0);
    send_word(1'b0, 24'h555555, 1'b1);

    set_gap('0);
    send_word(1'b1, 24'd10, 1'b0);
    send_word(1'b1, 24'd11, 1'b0);
    send_word(1'b1, 24'd10, 1'b1);
    // full event: 64 distinct times, then dropped hits, the last one closing
    base = HIT_TIME_W'($urandom());
    for (int h = 0; h < MAX_HITS_DEF + 3; h++)
      send_word(1'b1, base + HIT_TIME_W'((h * 37) % MAX_HITS_DEF), h == MAX_HITS_DEF + 2);
    send_word(1'b1, HIT_TIME_W'($urandom()), 1'b1);

    set_gap({GAP_W{1'b1}});
    send_word(1'b1, 24'h000000, 1'b0);
    send_word(1'b1, 24'hFFFFFF, 1'b1);

    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      r = $urandom_range(0, 5);
      case (r)
        0:       g = '0;
        1:       g = GAP_W'(1);
        2:       g = GAP_W'($urandom_range(2, 1000));
        3:       g = GAP_RESET;
        4:       g = GAP_W'($urandom());
        default: g = {GAP_W{1'b1}};
      endcase
      set_gap(g);
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        r = $urandom_range(0, 19);
        n = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, MAX_HITS_DEF) : $urandom_range(1, 8);
        send_event(n);
      end
      steady = 1'b0;
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d hit and close words over %0d events, %0d max_gap settings",
             items_sent, events_closed, gap_writes);
    $display("Checked %0d result words", results_checked);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/htg_pkg.sv
design/htg_in_if.sv
design/htg_out_if.sv
design/htg_cell.sv
design/htg_labeler.sv
design/hit_time_gap_clusterer_top.sv
tb/hit_time_gap_clusterer_checker.sv
tb/hit_time_gap_clusterer_top_tb.sv
